// ----- hw/rtl/tlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpm_pkg
// shared types and constants of the two-level page table mapper
// ----------------------------------------------------------------------------
package tlpm_pkg;

  localparam int unsigned MAX_TABLES_DEF = 64;

  localparam int unsigned VA_W      = 32;
  localparam int unsigned PA_W      = 32;
  localparam int unsigned FRAME_W   = 20;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned DIR_DEPTH = 1 << IDX_W;
  localparam int unsigned DIR_LSB   = 22;
  localparam int unsigned TAB_LSB   = 12;
  localparam int unsigned OFFS_W    = 12;
  localparam int unsigned STATUS_W  = 2;

  // result tdata: dir, tab, page frame, table frame, new table, run result
  localparam int unsigned OUT_BITS   = 2 * IDX_W + 2 * FRAME_W + 1 + VA_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned IN_DATA_W  = VA_W + PA_W;

  localparam logic [VA_W-1:0] PAGE_BYTES = VA_W'(4096);

  typedef enum logic [STATUS_W-1:0] {
    STAT_MAPPED    = 2'd0,
    STAT_MISALIGN  = 2'd1,
    STAT_EXHAUSTED = 2'd2,
    STAT_SKIPPED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/tlpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlpm_ctrl
// sequencer: directory clear after reset, item capture, lookup and commit
// ----------------------------------------------------------------------------
module tlpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tlpm_pkg::sts_t sts_i,
  output tlpm_pkg::cmd_t cmd_o
);
  import tlpm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // wait until the result register can take the item
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tlpm_datapath.sv -----
// ----------------------------------------------------------------------------
// tlpm_datapath
// directory store, pool counter, run state and result register
// ----------------------------------------------------------------------------
module tlpm_datapath #(
  parameter int unsigned MaxTables = tlpm_pkg::MAX_TABLES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tlpm_pkg::cmd_t                     cmd_i,
  output tlpm_pkg::sts_t                     sts_o,
  input  logic                               cfg_we_i,
  input  logic [tlpm_pkg::FRAME_W-1:0]       cfg_wdata_i,
  input  logic                               in_first_i,
  input  logic                               in_last_i,
  input  logic [tlpm_pkg::VA_W-1:0]          in_va_i,
  input  logic [tlpm_pkg::PA_W-1:0]          in_pa_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tlpm_pkg::status_e                  out_status_o,
  output logic [tlpm_pkg::IDX_W-1:0]         out_dir_o,
  output logic [tlpm_pkg::IDX_W-1:0]         out_tab_o,
  output logic [tlpm_pkg::FRAME_W-1:0]       out_page_frame_o,
  output logic [tlpm_pkg::FRAME_W-1:0]       out_table_frame_o,
  output logic                               out_new_table_o,
  output logic                               out_done_o,
  output logic [tlpm_pkg::VA_W-1:0]          out_result_o
);
  import tlpm_pkg::*;

  localparam int unsigned SlotW = (MaxTables > 1) ? $clog2(MaxTables) : 1;
  localparam int unsigned UsedW = $clog2(MaxTables + 1);
  localparam int unsigned EntW  = SlotW + 1;

  // directory store: {present, slot}
  logic [EntW-1:0] dir_mem [DIR_DEPTH];
  logic [EntW-1:0] dir_rd_q;

  logic [IDX_W-1:0]   clr_cnt_q;
  logic [FRAME_W-1:0] base_q;
  logic [UsedW-1:0]   used_q;
  logic [VA_W-1:0]    cur_va_q;
  logic [VA_W-1:0]    start_va_q;
  logic               failed_q;
  logic               last_q;
  logic [PA_W-1:0]    pa_q;

  logic               out_valid_q;
  status_e            status_q;
  logic [IDX_W-1:0]   dir_q, tab_q;
  logic [FRAME_W-1:0] pframe_q, tframe_q;
  logic               newt_q, done_q;
  logic [VA_W-1:0]    result_q;

  logic [VA_W-1:0]    rd_va;
  logic [IDX_W-1:0]   cur_dir, cur_tab;
  logic               present, misal, exhaust, alloc, fail;
  logic [SlotW-1:0]   slot;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [EntW-1:0]    mem_wd;
  status_e            status_d;
  logic [FRAME_W-1:0] pframe_d, tframe_d;
  logic               done_d;
  logic [VA_W-1:0]    result_d;

  assign rd_va   = in_first_i ? in_va_i : cur_va_q;
  assign cur_dir = cur_va_q[DIR_LSB +: IDX_W];
  assign cur_tab = cur_va_q[TAB_LSB +: IDX_W];
  assign present = dir_rd_q[SlotW];
  assign misal   = (pa_q[OFFS_W-1:0] != '0);
  assign exhaust = !present && (used_q >= UsedW'(MaxTables));
  assign fail    = !failed_q && (misal || exhaust);
  assign alloc   = !failed_q && !misal && !present && !exhaust;
  assign slot    = present ? dir_rd_q[SlotW-1:0] : used_q[SlotW-1:0];

  always_comb begin
    status_d = STAT_MAPPED;
    pframe_d = '0;
    tframe_d = '0;
    done_d   = 1'b0;
    result_d = '0;
    if (failed_q) begin
      status_d = STAT_SKIPPED;
    end else if (misal) begin
      status_d = STAT_MISALIGN;
      done_d   = 1'b1;
    end else if (exhaust) begin
      status_d = STAT_EXHAUSTED;
      done_d   = 1'b1;
    end else begin
      pframe_d = pa_q[TAB_LSB +: FRAME_W];
      tframe_d = base_q + {{(FRAME_W-SlotW){1'b0}}, slot};
      done_d   = last_q;
      result_d = last_q ? start_va_q : '0;
    end
  end

  // single write port: clear sweep or directory allocation
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_dir;
    mem_wd = {1'b1, slot};
    if (cmd_i.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else if (cmd_i.commit && alloc) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dir_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.capture) begin
      dir_rd_q <= dir_mem[rd_va[DIR_LSB +: IDX_W]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      base_q      <= '0;
      used_q      <= '0;
      cur_va_q    <= '0;
      start_va_q  <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.capture && in_first_i) begin
        cur_va_q   <= in_va_i;
        start_va_q <= in_va_i;
        failed_q   <= 1'b0;
      end
      if (cmd_i.commit) begin
        if (fail) begin
          failed_q <= 1'b1;
        end
        if (alloc) begin
          used_q <= used_q + UsedW'(1);
        end
        if (!failed_q && !fail) begin
          cur_va_q <= cur_va_q + PAGE_BYTES;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      last_q <= in_last_i;
      pa_q   <= in_pa_i;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      dir_q    <= cur_dir;
      tab_q    <= cur_tab;
      pframe_q <= pframe_d;
      tframe_q <= tframe_d;
      newt_q   <= alloc;
      done_q   <= done_d;
      result_q <= result_d;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == IDX_W'(DIR_DEPTH - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = status_q;
  assign out_dir_o         = dir_q;
  assign out_tab_o         = tab_q;
  assign out_page_frame_o  = pframe_q;
  assign out_table_frame_o = tframe_q;
  assign out_new_table_o   = newt_q;
  assign out_done_o        = done_q;
  assign out_result_o      = result_q;

endmodule

// ----- hw/rtl/two_level_page_table_mapper.sv -----
// ----------------------------------------------------------------------------
// two_level_page_table_mapper
// x86 32-bit style two-level page table mapper, 4 KiB pages
// ----------------------------------------------------------------------------
// Each input item maps one physical page into a run of consecutive virtual
// pages; tuser marks the first item of a run (its virtual address starts the
// run) and tlast the last. Every item gives one result item carrying the
// directory and table indices, the page frame and the frame of the page
// table used, which together form the page entry write for the table memory
// downstream; new_table flags that a fresh pool table was allocated and must
// be cleared there first. An item is first captured while the directory store
// is read, then decided and loaded into the result register; a result not
// yet taken holds the next commit. After reset the 1024-entry directory
// store is cleared by a sweep over all its entries, during which no item is
// taken; configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
module two_level_page_table_mapper #(
  parameter int unsigned MaxTables = tlpm_pkg::MAX_TABLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: table_base_frame
  input  logic                                cfg_we_i,
  input  logic [tlpm_pkg::FRAME_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tlpm_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // virt_addr, phys_addr
  input  logic                                s_axis_tuser,  // first_of_run
  input  logic                                s_axis_tlast,  // last_of_run
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // dir_index, tab_index, page_frame, table_frame, new_table, run_result, pad
  output logic [tlpm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [tlpm_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
  output logic                                m_axis_tlast   // run_done
);
  import tlpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  status_e            out_status;
  logic [IDX_W-1:0]   out_dir, out_tab;
  logic [FRAME_W-1:0] out_pframe, out_tframe;
  logic               out_newt;
  logic [VA_W-1:0]    out_result;

  // sequencer
  tlpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // directory store, run state and result register
  tlpm_datapath #(
    .MaxTables (MaxTables)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_first_i        (s_axis_tuser),
    .in_last_i         (s_axis_tlast),
    .in_va_i           (s_axis_tdata[VA_W-1:0]),
    .in_pa_i           (s_axis_tdata[VA_W +: PA_W]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_status_o      (out_status),
    .out_dir_o         (out_dir),
    .out_tab_o         (out_tab),
    .out_page_frame_o  (out_pframe),
    .out_table_frame_o (out_tframe),
    .out_new_table_o   (out_newt),
    .out_done_o        (m_axis_tlast),
    .out_result_o      (out_result)
  );

  // result packing, lowest field first, zero padded to whole bytes
  assign m_axis_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}},
                         out_result, out_newt, out_tframe, out_pframe,
                         out_tab, out_dir};
  assign m_axis_tuser = out_status;

endmodule
